@@ rtl/core/mpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Memory pressure monitor package
// Sizes, operation and error codes, controller states and the command and
// status groups shared by the monitor's modules.
// ----------------------------------------------------------------------------
package mpm_pkg;

    localparam int NUM_TYPES    = 4;
    localparam int AMOUNT_WIDTH = 48;

    localparam int OP_W     = 3;
    localparam int TYPE_W   = 2;
    localparam int MASK_W   = 4;
    localparam int LVL_W    = 2;
    localparam int PCT_W    = 7;
    localparam int DELTA_W  = AMOUNT_WIDTH + 1;
    localparam int PROD_W   = AMOUNT_WIDTH + PCT_W;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int QIDX_W   = $clog2(MASK_W);
    localparam int QCOUNT   = (NUM_TYPES < MASK_W) ? NUM_TYPES : MASK_W;

    localparam logic [PCT_W-1:0] PCT_HUNDRED   = PCT_W'(100);
    localparam logic [PCT_W-1:0] LOW_PCT_RESET = PCT_W'(50);
    localparam logic [PCT_W-1:0] MOD_PCT_RESET = PCT_W'(30);

    localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD        = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY_MAX  = 3'd2;
    localparam logic [OP_W-1:0] OP_PRESS_WAIT = 3'd3;
    localparam logic [OP_W-1:0] OP_MEM_WAIT   = 3'd4;

    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MOD  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_PCT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load_item;
        logic prep;
        logic sel_q;
        logic mul;
        logic cmp;
        logic q_next;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic q_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/mpm_if.sv @@
// ----------------------------------------------------------------------------
// Memory pressure monitor channels
// Request, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface mpm_in_if;
    import mpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [TYPE_W-1:0]          mem_type;
    logic signed [DELTA_W-1:0]  delta;
    logic [AMOUNT_WIDTH-1:0]    total_value;
    logic [AMOUNT_WIDTH-1:0]    free_value;
    logic [MASK_W-1:0]          type_mask;
    logic [LVL_W-1:0]           level;
    logic [AMOUNT_WIDTH-1:0]    request_size;

    modport source (
        output valid, operation, mem_type, delta, total_value, free_value,
               type_mask, level, request_size,
        input  ready
    );
    modport sink (
        input  valid, operation, mem_type, delta, total_value, free_value,
               type_mask, level, request_size,
        output ready
    );
endinterface

interface mpm_out_if;
    import mpm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LVL_W-1:0]        pressure_level;
    logic [AMOUNT_WIDTH-1:0] free_now;
    logic                    pressure_raised;
    logic                    wake_memory_waiters;
    logic                    condition_met;
    logic [1:0]              error;

    modport source (
        output valid, pressure_level, free_now, pressure_raised,
               wake_memory_waiters, condition_met, error,
        input  ready
    );
    modport sink (
        input  valid, pressure_level, free_now, pressure_raised,
               wake_memory_waiters, condition_met, error,
        output ready
    );
endinterface

interface mpm_cfg_if;
    import mpm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_W-1:0]    index;
    logic [AMOUNT_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/memory_pressure_monitor.sv @@
// ----------------------------------------------------------------------------
// Memory pressure monitor
// Keeps total, free and pressure level for each memory type and answers
// init, add, query and wait-condition requests, one result per request.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to its result entering the output
// register through the add check, the registered products of the level unit,
// the threshold compares and the store update, which waits until the output
// register is free. A query of the highest level runs the shared level unit
// once for each of the first min(NUM_TYPES, 4) memory types. A new request
// is taken in the cycle its predecessor finishes, while that result waits in
// the output register. Configuration writes are taken in any cycle, but should
// only be issued while no request is in flight.
module memory_pressure_monitor (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpm_in_if.sink    i_in,
    mpm_out_if.source o_out,
    mpm_cfg_if.sink   i_cfg
);
    import mpm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    mpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mpm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

@@ rtl/core/mpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Memory pressure monitor controller
// Sequences each item through prepare, multiply, compare and finish steps,
// looping the level unit over the memory types for a pressure query.
// ----------------------------------------------------------------------------
module mpm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mpm_pkg::t_dp_sts i_sts,
    output mpm_pkg::t_dp_cmd o_cmd
);
    import mpm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep  = 1'b1;
                o_cmd.sel_q = i_sts.is_query;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.is_query && !i_sts.q_last) begin
                    o_cmd.q_next = 1'b1;
                    n_state      = ST_PREP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_in_ready   = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = ST_PREP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/mpm_dp.sv @@
// ----------------------------------------------------------------------------
// Memory pressure monitor datapath
// Per-type stores, configuration registers, the add check, the shared level
// unit (products, then compares) and the result register.
// ----------------------------------------------------------------------------
module mpm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mpm_in_if.sink           i_in,
    mpm_out_if.source        o_out,
    mpm_cfg_if.sink          i_cfg,
    input  mpm_pkg::t_dp_cmd i_cmd,
    output mpm_pkg::t_dp_sts o_sts
);
    import mpm_pkg::*;

    logic [AMOUNT_WIDTH-1:0] r_total_store [NUM_TYPES];
    logic [AMOUNT_WIDTH-1:0] r_free_store  [NUM_TYPES];
    logic [LVL_W-1:0]        r_level_store [NUM_TYPES];

    logic [PCT_W-1:0]        r_low_pct;
    logic [PCT_W-1:0]        r_mod_pct;
    logic [AMOUNT_WIDTH-1:0] r_thr;

    logic [OP_W-1:0]            r_op;
    logic [TYPE_W-1:0]          r_type;
    logic signed [DELTA_W-1:0]  r_delta;
    logic [AMOUNT_WIDTH-1:0]    r_total_in;
    logic [AMOUNT_WIDTH-1:0]    r_free_in;
    logic [MASK_W-1:0]          r_mask;
    logic [LVL_W-1:0]           r_want;
    logic [AMOUNT_WIDTH-1:0]    r_req;

    logic [AMOUNT_WIDTH-1:0] r_cand_tot;
    logic [AMOUNT_WIDTH-1:0] r_cand_free;
    t_err                    r_err;
    logic                    r_cond4;
    logic [PROD_W-1:0]       r_f100;
    logic [PROD_W-1:0]       r_tl;
    logic [PROD_W-1:0]       r_tm;
    logic                    r_tot_zero;
    logic [LVL_W-1:0]        r_new_lvl;
    logic [LVL_W-1:0]        r_acc;
    logic [QIDX_W-1:0]       r_qidx;

    logic                    r_out_valid;
    logic [LVL_W-1:0]        r_o_level;
    logic [AMOUNT_WIDTH-1:0] r_o_free;
    logic                    r_o_raised;
    logic                    r_o_wake;
    logic                    r_o_cond;
    t_err                    r_o_err;

    logic [IDX_W-1:0]        w_addr;
    logic [AMOUNT_WIDTH-1:0] w_rd_total;
    logic [AMOUNT_WIDTH-1:0] w_rd_free;
    logic [LVL_W-1:0]        w_rd_level;
    logic                    w_type_ok;
    logic [DELTA_W-1:0]      w_mag_neg;
    logic [DELTA_W-1:0]      w_sum;
    logic                    w_under;
    logic                    w_over;
    logic [AMOUNT_WIDTH-1:0] w_nf;
    t_err                    w_err;
    logic [AMOUNT_WIDTH-1:0] w_cand_tot;
    logic [AMOUNT_WIDTH-1:0] w_cand_free;
    logic [LVL_W-1:0]        w_lvl;
    logic                    w_commit;
    logic                    w_cond3;
    logic [LVL_W-1:0]        w_res_level;
    logic [AMOUNT_WIDTH-1:0] w_res_free;
    logic                    w_res_raised;
    logic                    w_res_wake;
    logic                    w_res_cond;
    t_err                    w_res_err;

    assign w_addr     = i_cmd.sel_q ? IDX_W'(r_qidx) : IDX_W'(r_type);
    assign w_rd_total = r_total_store[w_addr];
    assign w_rd_free  = r_free_store[w_addr];
    assign w_rd_level = r_level_store[w_addr];
    assign w_type_ok  = 32'(r_type) < NUM_TYPES;

    assign o_sts.is_query = (r_op == OP_QUERY_MAX);
    assign o_sts.q_last   = (r_qidx == QIDX_W'(QCOUNT - 1));
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pct <= LOW_PCT_RESET;
            r_mod_pct <= MOD_PCT_RESET;
            r_thr     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LOW_PCT:   r_low_pct <= i_cfg.data[PCT_W-1:0];
                CFG_MOD_PCT:   r_mod_pct <= i_cfg.data[PCT_W-1:0];
                CFG_THRESHOLD: r_thr     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op       <= i_in.operation;
            r_type     <= i_in.mem_type;
            r_delta    <= i_in.delta;
            r_total_in <= i_in.total_value;
            r_free_in  <= i_in.free_value;
            r_mask     <= i_in.type_mask;
            r_want     <= i_in.level;
            r_req      <= i_in.request_size;
        end
    end

    // Add check: a negative delta underflows when its magnitude exceeds free,
    // a positive one overflows when free plus delta exceeds total.
    always_comb begin
        w_mag_neg = DELTA_W'(-r_delta);
        w_sum     = {1'b0, w_rd_free} + {1'b0, r_delta[AMOUNT_WIDTH-1:0]};
        w_under   = w_mag_neg > {1'b0, w_rd_free};
        w_over    = w_sum > {1'b0, w_rd_total};
        if (r_delta[DELTA_W-1]) begin
            w_nf  = w_rd_free - w_mag_neg[AMOUNT_WIDTH-1:0];
            w_err = w_under ? ERR_UNDERFLOW : ERR_NONE;
        end else begin
            w_nf  = w_sum[AMOUNT_WIDTH-1:0];
            w_err = w_over ? ERR_OVERFLOW : ERR_NONE;
        end
        w_cand_tot  = w_rd_total;
        w_cand_free = w_rd_free;
        if (r_op == OP_INIT) begin
            w_cand_tot  = r_total_in;
            w_cand_free = r_free_in;
        end else if (r_op == OP_ADD) begin
            w_cand_free = w_nf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_cand_tot  <= w_cand_tot;
            r_cand_free <= w_cand_free;
            r_err       <= (r_op == OP_ADD) ? w_err : ERR_NONE;
            r_cond4     <= {1'b0, w_rd_free} < ({1'b0, r_req} + {1'b0, r_thr});
        end
        if (i_cmd.mul) begin
            r_f100     <= PROD_W'(r_cand_free) * PROD_W'(PCT_HUNDRED);
            r_tl       <= PROD_W'(r_cand_tot) * PROD_W'(r_low_pct);
            r_tm       <= PROD_W'(r_cand_tot) * PROD_W'(r_mod_pct);
            r_tot_zero <= (r_cand_tot == '0);
        end
    end

    always_comb begin
        if (r_tot_zero) begin
            w_lvl = LVL_HIGH;
        end else if (r_f100 >= r_tl) begin
            w_lvl = LVL_LOW;
        end else if (r_f100 >= r_tm) begin
            w_lvl = LVL_MOD;
        end else begin
            w_lvl = LVL_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_qidx <= '0;
            r_acc  <= LVL_LOW;
        end else begin
            if (i_cmd.cmp) begin
                r_new_lvl <= w_lvl;
                if (r_mask[r_qidx] && (w_lvl > r_acc)) begin
                    r_acc <= w_lvl;
                end
            end
            if (i_cmd.q_next) begin
                r_qidx <= r_qidx + 1'b1;
            end
        end
    end

    always_comb begin
        w_cond3 = 1'b0;
        for (int i = 0; i < QCOUNT; i++) begin
            if (r_mask[i] && (r_level_store[i] >= r_want)) begin
                w_cond3 = 1'b1;
            end
        end
    end

    always_comb begin
        w_commit = w_type_ok &&
                   ((r_op == OP_INIT) || ((r_op == OP_ADD) && (r_err == ERR_NONE)));
        w_res_raised = 1'b0;
        w_res_wake   = 1'b0;
        w_res_err    = ERR_NONE;
        w_res_cond   = 1'b0;
        if ((r_op == OP_ADD) && w_type_ok) begin
            w_res_err = r_err;
            if (r_err == ERR_NONE) begin
                w_res_raised = r_new_lvl > w_rd_level;
                w_res_wake   = !w_res_raised && (r_cand_free >= r_thr);
            end
        end
        if (r_op == OP_PRESS_WAIT) begin
            w_res_cond = w_cond3;
        end else if ((r_op == OP_MEM_WAIT) && w_type_ok) begin
            w_res_cond = r_cond4;
        end
        if (r_op == OP_QUERY_MAX) begin
            w_res_level = r_acc;
        end else if (!w_type_ok) begin
            w_res_level = LVL_LOW;
        end else begin
            w_res_level = w_commit ? r_new_lvl : w_rd_level;
        end
        if (!w_type_ok) begin
            w_res_free = '0;
        end else begin
            w_res_free = w_commit ? r_cand_free : w_rd_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                r_total_store[i] <= '0;
                r_free_store[i]  <= '0;
                r_level_store[i] <= LVL_LOW;
            end
        end else if (i_cmd.finish && w_commit) begin
            if (r_op == OP_INIT) begin
                r_total_store[w_addr] <= r_cand_tot;
            end
            r_free_store[w_addr]  <= r_cand_free;
            r_level_store[w_addr] <= r_new_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_level  <= w_res_level;
            r_o_free   <= w_res_free;
            r_o_raised <= w_res_raised;
            r_o_wake   <= w_res_wake;
            r_o_cond   <= w_res_cond;
            r_o_err    <= w_res_err;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.pressure_level      = r_o_level;
    assign o_out.free_now            = r_o_free;
    assign o_out.pressure_raised     = r_o_raised;
    assign o_out.wake_memory_waiters = r_o_wake;
    assign o_out.condition_met       = r_o_cond;
    assign o_out.error               = r_o_err;

endmodule
